>>> rtl/pscm_pkg.sv
// Shared constants and control types for the point set mean centering block.
`default_nettype none
package pscm_pkg;

	localparam int COORD_W     = 32;
	localparam int STORE_DEPTH = 64;
	localparam int MAX_POINTS_DEF = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	// Sums of up to STORE_DEPTH signed 32-bit values need this many bits.
	localparam int SUM_W       = COORD_W + $clog2(STORE_DEPTH);
	localparam int DIV_CNT_W   = $clog2(SUM_W);
	localparam int RAM_W       = 2 * COORD_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_READ,
		ST_FILL
	} state_t;

	typedef struct packed {
		logic load_point;
		logic div_init;
		logic div_step;
		logic cent_load;
		logic rd_en;
		logic out_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/pscm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pscm_ram
	import pscm_pkg::*;
#(
	parameter int WIDTH = RAM_W,
	parameter int DEPTH = STORE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/pscm_ctrl.sv
// Controller state machine: load, divide, then replay the stored points.
`default_nettype none
module pscm_ctrl
	import pscm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    last_point,
	input  wire status_t status,
	output logic         in_stall,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_LOAD);
	assign accept   = in_valid && (state_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && last_point) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_FILL;
			ST_FILL: begin
				if (status.out_free) begin
					state_d = status.emit_last ? ST_LOAD : ST_READ;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: cmd.load_point = accept;
			ST_PREP: cmd.div_init = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_READ: begin
				cmd.rd_en     = 1'b1;
				cmd.cent_load = 1'b1;
			end
			ST_FILL: begin
				cmd.out_load = status.out_free;
				cmd.clear    = status.out_free && status.emit_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/pscm_dp.sv
// Datapath: point store, running sums, serial divider and output register.
`default_nettype none
module pscm_dp
	import pscm_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output status_t                        status,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output logic signed [COORD_W-1:0]      offset_x,
	output logic signed [COORD_W-1:0]      offset_y,
	output logic signed [COORD_W-1:0]      centroid_x,
	output logic signed [COORD_W-1:0]      centroid_y,
	output logic                           end_of_run,
	output logic                           points_dropped
);

	logic signed [SUM_W-1:0]   x_sum_q, y_sum_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      drop_q;
	logic                      has_room;

	// Divider registers: the magnitude shifts out while the quotient shifts in.
	logic [SUM_W-1:0]          dx_q, dy_q;
	logic [CNT_W-1:0]          rx_q, ry_q;
	logic                      negx_q, negy_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [CNT_W:0]            tx, ty;
	logic                      gex, gey;

	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [RAM_W-1:0]          rd_word;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic signed [COORD_W:0]   diff_x, diff_y;
	logic signed [COORD_W-1:0] sat_x, sat_y;
	logic                      out_valid_q;

	assign has_room = (count_q < CNT_W'(MAX_POINTS));

	pscm_ram #(
		.WIDTH (RAM_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.load_point && has_room),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({point_x, point_y}),
		.re    (cmd.rd_en),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear) begin
				x_sum_q <= '0;
				y_sum_q <= '0;
				count_q <= '0;
				drop_q  <= 1'b0;
				idx_q   <= '0;
			end else begin
				if (cmd.load_point) begin
					if (has_room) begin
						x_sum_q <= x_sum_q + SUM_W'(point_x);
						y_sum_q <= y_sum_q + SUM_W'(point_y);
						count_q <= count_q + 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
				end
				if (cmd.out_load) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// One restoring step per cycle; remainders stay below the point count.
	assign tx  = {rx_q, dx_q[SUM_W-1]};
	assign ty  = {ry_q, dy_q[SUM_W-1]};
	assign gex = (tx >= {1'b0, count_q});
	assign gey = (ty >= {1'b0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			negx_q <= x_sum_q[SUM_W-1];
			negy_q <= y_sum_q[SUM_W-1];
			dx_q   <= x_sum_q[SUM_W-1] ? SUM_W'(-x_sum_q) : SUM_W'(x_sum_q);
			dy_q   <= y_sum_q[SUM_W-1] ? SUM_W'(-y_sum_q) : SUM_W'(y_sum_q);
			rx_q   <= '0;
			ry_q   <= '0;
		end else if (cmd.div_step) begin
			dx_q <= {dx_q[SUM_W-2:0], gex};
			dy_q <= {dy_q[SUM_W-2:0], gey};
			rx_q <= gex ? CNT_W'(tx - {1'b0, count_q}) : tx[CNT_W-1:0];
			ry_q <= gey ? CNT_W'(ty - {1'b0, count_q}) : ty[CNT_W-1:0];
		end
		if (cmd.cent_load) begin
			cx_q <= negx_q ? -dx_q[COORD_W-1:0] : dx_q[COORD_W-1:0];
			cy_q <= negy_q ? -dy_q[COORD_W-1:0] : dy_q[COORD_W-1:0];
		end
	end

	assign rd_x   = rd_word[RAM_W-1:COORD_W];
	assign rd_y   = rd_word[COORD_W-1:0];
	assign diff_x = {rd_x[COORD_W-1], rd_x} - {cx_q[COORD_W-1], cx_q};
	assign diff_y = {rd_y[COORD_W-1], rd_y} - {cy_q[COORD_W-1], cy_q};

	always_comb begin
		sat_x = diff_x[COORD_W-1:0];
		if (diff_x[COORD_W] != diff_x[COORD_W-1]) begin
			sat_x = diff_x[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
		sat_y = diff_y[COORD_W-1:0];
		if (diff_y[COORD_W] != diff_y[COORD_W-1]) begin
			sat_y = diff_y[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			offset_x       <= sat_x;
			offset_y       <= sat_y;
			centroid_x     <= cx_q;
			centroid_y     <= cy_q;
			end_of_run     <= status.emit_last;
			points_dropped <= drop_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.div_done  = (div_cnt_q == DIV_CNT_W'(SUM_W - 1));
	assign status.emit_last = ((idx_q + 1'b1) == count_q);
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

>>> rtl/point_set_mean_centering_top.sv
// Top level of the point set mean centering block.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+----------------------------------------
//  in      | receive   | in_valid / in_stall | point_x, point_y, last_point
//  out     | send      | out_valid/out_stall | offset_x, offset_y, centroid_x,
//          |           |                     | centroid_y, end_of_run, points_dropped
//
// Points load one per cycle while in_stall is low. The last point of a set starts
// a setup step and then a serial divide, one quotient bit per cycle for x and y.
// Each result then takes a read state for the registered store read and a fill state.
// Reset clears the sums, count, drop flag and control; store contents are not cleared.
// A stalled result holds in the output register; the next store read waits for it.
`default_nettype none
module point_set_mean_centering_top
	import pscm_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic                      last_point,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [COORD_W-1:0]      offset_x,
	output logic signed [COORD_W-1:0]      offset_y,
	output logic signed [COORD_W-1:0]      centroid_x,
	output logic signed [COORD_W-1:0]      centroid_y,
	output logic                           end_of_run,
	output logic                           points_dropped
);

	cmd_t    cmd;
	status_t status;

	pscm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (last_point),
		.status     (status),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	pscm_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.point_x        (point_x),
		.point_y        (point_y),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.offset_x       (offset_x),
		.offset_y       (offset_y),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.end_of_run     (end_of_run),
		.points_dropped (points_dropped)
	);

endmodule
`default_nettype wire

>>> rtl/pscm_chk.sv
// Port-level checker for the point set mean centering block, with its bind.
`default_nettype none
module pscm_chk
	import pscm_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               last_point,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [COORD_W-1:0] offset_x,
	input wire logic [COORD_W-1:0] centroid_x,
	input wire logic [COORD_W-1:0] centroid_y,
	input wire logic               end_of_run
);

	// A stalled word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(offset_x))
		else $error("output word changed while stalled");

	// The last point of a set closes the input until the run is replayed.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_point |=> in_stall)
		else $error("input open right after the last point");

	// While a run is being replayed no new point is taken.
	a_run_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_run |-> in_stall)
		else $error("input open in the middle of a run");

	// Within a run the centroid does not move between words.
	a_centroid_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !end_of_run |=> $stable(centroid_x) && $stable(centroid_y))
		else $error("centroid changed within a run");

	// The handshake outputs are always known once out of reset.
	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("unknown value on a handshake output");

endmodule

bind point_set_mean_centering_top pscm_chk u_pscm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_point (last_point),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.offset_x   (offset_x),
	.centroid_x (centroid_x),
	.centroid_y (centroid_y),
	.end_of_run (end_of_run)
);
`default_nettype wire
